### hw/rtl/b2d_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the binary to decimal ASCII digit emitter.
// Depends on nothing; every other file of the block imports it.
package b2d_pkg;

  // Width of the binary input value and of the digit count field.
  localparam int unsigned NUM_BITS      = 32;
  localparam int unsigned COUNT_W       = 4;
  // Default for the number of decimal digits kept.
  localparam int unsigned MAX_DIGITS_DEF = 10;
  // Double dabble bit steps done by one pipeline stage, and the stage count.
  localparam int unsigned STAGE_BITS    = 8;
  localparam int unsigned NUM_STAGES    = NUM_BITS / STAGE_BITS;
  // ASCII code of the character '0'.
  localparam logic [5:0]  ASCII_ZERO    = 6'd48;

  typedef struct packed {
    logic [NUM_BITS-1:0] number;
    logic [COUNT_W-1:0]  digit_count;
  } in_beat_t;

  typedef struct packed {
    logic [5:0] digit_char;
    logic       last;
  } out_beat_t;

endpackage

### hw/rtl/binary_to_decimal_ascii_digits_top.sv
`timescale 1ns / 1ps
// Top level of the binary to decimal ASCII digit emitter.
// Depends on b2d_pkg, b2d_dabble_stage and b2d_serializer.
//
//   Channel | Direction | Handshake                  | Beat
//   --------+-----------+----------------------------+-------------------------
//   in      | input     | in_valid_i / in_ready_o    | number, digit_count
//   out     | output    | out_valid_o / out_ready_i  | digit_char, last
//
// Conversion runs through NUM_STAGES register stages of double dabble, eight
// bit steps each, so a new input beat can enter every cycle when nothing
// stalls. An item with count n leaves min(n, MAX_DIGITS) output beats, one
// per cycle while out_ready_i is high, and one with a count of zero leaves
// nothing; the serializer takes a new item as it sends the previous one's
// last digit. Digits pass the stage registers, then the output register.
// Reset clears only the valid flags and the serializer state.
// Back pressure on the output ripples back stage by stage; nothing is dropped.
module binary_to_decimal_ascii_digits_top #(
  parameter int unsigned MAX_DIGITS = b2d_pkg::MAX_DIGITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  b2d_pkg::in_beat_t  in_beat_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output b2d_pkg::out_beat_t out_beat_o
);
  import b2d_pkg::*;

  localparam int unsigned BCD_W = 4 * MAX_DIGITS;

  // Pipeline links: index k is the input of stage k, NUM_STAGES the output.
  logic                valid_s [NUM_STAGES+1];
  logic                ready_s [NUM_STAGES+1];
  logic [NUM_BITS-1:0] bin_s   [NUM_STAGES+1];
  logic [BCD_W-1:0]    bcd_s   [NUM_STAGES+1];
  logic [COUNT_W-1:0]  count_s [NUM_STAGES+1];

  // Counts above the digit limit saturate. A zero count produces no digits,
  // so such a beat is accepted and simply not passed down the pipeline.
  logic [COUNT_W-1:0] count_clamped;
  assign count_clamped = (in_beat_i.digit_count > COUNT_W'(MAX_DIGITS))
                         ? COUNT_W'(MAX_DIGITS) : in_beat_i.digit_count;

  assign valid_s[0] = in_valid_i && (count_clamped != '0);
  assign bin_s[0]   = in_beat_i.number;
  assign bcd_s[0]   = '0;
  assign count_s[0] = count_clamped;
  assign in_ready_o = ready_s[0];

  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
    b2d_dabble_stage #(
      .MAX_DIGITS (MAX_DIGITS)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_s[k]),
      .ready_o (ready_s[k]),
      .bin_i   (bin_s[k]),
      .bcd_i   (bcd_s[k]),
      .count_i (count_s[k]),
      .valid_o (valid_s[k+1]),
      .ready_i (ready_s[k+1]),
      .bin_o   (bin_s[k+1]),
      .bcd_o   (bcd_s[k+1]),
      .count_o (count_s[k+1])
    );
  end

  // The binary remainder is fully shifted out after the last stage.
  logic unused_bin;
  assign unused_bin = ^bin_s[NUM_STAGES];

  b2d_serializer #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_serializer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (valid_s[NUM_STAGES] || (unused_bin && 1'b0)),
    .ready_o     (ready_s[NUM_STAGES]),
    .bcd_i       (bcd_s[NUM_STAGES]),
    .count_i     (count_s[NUM_STAGES]),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o)
  );

endmodule

### hw/rtl/b2d_dabble_stage.sv
`timescale 1ns / 1ps
// One register stage of the double dabble converter: shifts in STAGE_BITS bits.
// Depends on b2d_pkg.
module b2d_dabble_stage #(
  parameter int unsigned MAX_DIGITS = b2d_pkg::MAX_DIGITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [b2d_pkg::NUM_BITS-1:0]  bin_i,
  input  logic [4*MAX_DIGITS-1:0]       bcd_i,
  input  logic [b2d_pkg::COUNT_W-1:0]   count_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [b2d_pkg::NUM_BITS-1:0]  bin_o,
  output logic [4*MAX_DIGITS-1:0]       bcd_o,
  output logic [b2d_pkg::COUNT_W-1:0]   count_o
);
  import b2d_pkg::*;

  localparam int unsigned BCD_W = 4 * MAX_DIGITS;

  logic                valid_q;
  logic [NUM_BITS-1:0] bin_q, bin_d;
  logic [BCD_W-1:0]    bcd_q, bcd_d;
  logic [COUNT_W-1:0]  count_q;

  // Add three to every digit of five or more, then shift one bit in.
  // Digits above the kept width are simply lost, which leaves the value
  // modulo a power of ten in the kept digits.
  always_comb begin
    bin_d = bin_i;
    bcd_d = bcd_i;
    for (int s = 0; s < int'(STAGE_BITS); s++) begin
      for (int d = 0; d < int'(MAX_DIGITS); d++) begin
        if (bcd_d[4*d +: 4] >= 4'd5) begin
          bcd_d[4*d +: 4] = bcd_d[4*d +: 4] + 4'd3;
        end
      end
      bcd_d = {bcd_d[BCD_W-2:0], bin_d[NUM_BITS-1]};
      bin_d = {bin_d[NUM_BITS-2:0], 1'b0};
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      bin_q   <= bin_d;
      bcd_q   <= bcd_d;
      count_q <= count_i;
    end
  end

  assign valid_o = valid_q;
  assign bin_o   = bin_q;
  assign bcd_o   = bcd_q;
  assign count_o = count_q;

`ifndef NO_ASSERTIONS
  // Items with no digits never enter the pipeline, and counts are clamped.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (count_q != '0) && (count_q <= COUNT_W'(MAX_DIGITS)))
    else $error("stage holds an item with an illegal digit count");
  // A stalled stage keeps its item.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !ready_i) |=> valid_q && $stable(bcd_q) && $stable(count_q))
    else $error("stage lost or changed an item under stall");
`endif

endmodule

### hw/rtl/b2d_serializer.sv
`timescale 1ns / 1ps
// Digit serializer: sends the converted digits one beat per cycle while out_ready_i is high, MSD first.
// Depends on b2d_pkg.
module b2d_serializer #(
  parameter int unsigned MAX_DIGITS = b2d_pkg::MAX_DIGITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic [4*MAX_DIGITS-1:0]     bcd_i,
  input  logic [b2d_pkg::COUNT_W-1:0] count_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output b2d_pkg::out_beat_t          out_beat_o
);
  import b2d_pkg::*;

  localparam int unsigned IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  logic [3:0]         digits_q [MAX_DIGITS];
  logic [COUNT_W-1:0] rem_q, rem_d;
  logic               busy_q, busy_d;
  logic               out_valid_q, out_valid_d;
  out_beat_t          out_q, out_d;
  logic               out_free;
  logic               emit;
  logic               load;
  logic [COUNT_W-1:0] rem_m1;
  logic [IDX_W-1:0]   idx;

  assign out_free = !out_valid_q || out_ready_i;
  assign emit     = busy_q && out_free;
  assign ready_o  = !busy_q || (emit && rem_q == COUNT_W'(1));
  assign load     = valid_i && ready_o;
  assign rem_m1   = rem_q - COUNT_W'(1);
  assign idx      = rem_m1[IDX_W-1:0];

  always_comb begin
    rem_d       = rem_q;
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_free) begin
      out_valid_d = emit;
    end
    if (emit) begin
      out_d.digit_char = ASCII_ZERO | {2'b00, digits_q[idx]};
      out_d.last       = (rem_q == COUNT_W'(1));
      rem_d            = rem_m1;
      busy_d           = (rem_q != COUNT_W'(1));
    end
    if (load) begin
      rem_d  = count_i;
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (load) begin
      for (int d = 0; d < int'(MAX_DIGITS); d++) begin
        digits_q[d] <= bcd_i[4*d +: 4];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

`ifndef NO_ASSERTIONS
  // While a run is in progress the remaining count stays within the digit limit.
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (rem_q != '0) && (rem_q <= COUNT_W'(MAX_DIGITS)))
    else $error("serializer remaining count out of range");
  // Every digit sent is a decimal character.
  a_digit_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.digit_char >= 6'd48) && (out_q.digit_char <= 6'd57))
    else $error("digit character outside 0 to 9");
  // Sending the last digit with no new item ends the run.
  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && rem_q == COUNT_W'(1) && !valid_i) |=> !busy_q)
    else $error("serializer stayed busy after the last digit");
  // A new run can only start once the previous one sends its last digit.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && load) |-> emit && out_d.last)
    else $error("serializer loaded an item in the middle of a run");
`endif

endmodule
